// ===== rtl/sstf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types, constants and helpers of the seven-segment frame formatter.
// ----------------------------------------------------------------------------
package sstf_pkg;

   // Input transaction: one formatting request
   typedef struct packed {
      logic        action;
      logic [31:0] value;
      logic        colon_on;
      logic        keep_leading_zeros;
   } req_type;

   // Output transaction: one five-byte display frame
   typedef struct packed {
      logic [7:0] digit0_segments;
      logic [7:0] digit1_segments;
      logic [7:0] colon_segments;
      logic [7:0] digit2_segments;
      logic [7:0] digit3_segments;
   } rsp_type;

   // Action codes
   localparam logic ACTION_NUMBER = 1'b0;
   localparam logic ACTION_TIME   = 1'b1;

   // Display format picked by the front end
   typedef enum logic [1:0] {
      KIND_NUMBER,      // four low decimal digits
      KIND_CLOCK,       // MM:SS
      KIND_CLOCK_MAX,   // MM:SS pinned at 99:59
      KIND_CENTI        // SS.cs
   } kind_type;

   // Classified work item handed from front end to back end
   typedef struct packed {
      kind_type    kind;
      logic [12:0] quot;   // n/10000, seconds, or centiseconds
      logic [15:0] num;    // number mode operand
      logic        colon_on;
      logic        keep;
   } work_type;

   // Time thresholds in milliseconds
   localparam logic [31:0] SPLIT_MS = 32'd60000;
   localparam logic [31:0] MAX_MS   = 32'd6000000;   // 100 minutes

   // Reset value of the colon pattern register
   localparam logic [7:0] COLON_RESET = 8'h02;

   // Decimal point bit of a segment byte
   localparam logic [7:0] DOT_BIT = 8'h80;

   // Saturated clock display
   localparam logic [6:0] MAX_MINUTES = 7'd99;
   localparam logic [6:0] MAX_SECONDS = 7'd59;

   // Segment patterns of the decimal digits
   localparam logic [7:0] SEG_TABLE [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // Segment byte of one decimal digit, blank for codes above nine
   function automatic logic [7:0] segment_of(input logic [3:0] digit);
      logic [7:0] seg;
      seg = 8'h00;
      if (digit <= 4'd9) begin
         seg = SEG_TABLE[digit];
      end
      return seg;
   endfunction

endpackage

// ===== rtl/sstf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_front
// Accepts requests, picks the display format and does the first
// reciprocal division (by 10000, 1000 or 10) on one shared multiplier.
// ----------------------------------------------------------------------------
module sstf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sstf_pkg::req_type req_data,
   output logic              work_valid,
   input  logic              work_ready,
   output sstf_pkg::work_type work_data
);

   // Reciprocals: floor(x/d) = (x*m) >> s over the operand range in use
   localparam logic [23:0] RECIP_10000 = 24'd107375;    // s = 30, x < 2^16
   localparam logic [23:0] RECIP_1000  = 24'd8589935;   // s = 33, x < 6e6
   localparam logic [23:0] RECIP_10    = 24'd52429;     // s = 19, x < 2^16

   logic               front_valid_ff, front_valid_in;
   sstf_pkg::work_type front_work_ff, front_work_in;
   sstf_pkg::kind_type kind;
   logic [22:0]        operand;
   logic [23:0]        recip;
   logic [46:0]        product;
   logic               req_fire;

   assign req_ready  = !front_valid_ff || work_ready;
   assign req_fire   = req_valid && req_ready;
   assign work_valid = front_valid_ff;
   assign work_data  = front_work_ff;

   // Classify the transaction and pick the divider operands
   always_comb begin
      if (req_data.action == sstf_pkg::ACTION_NUMBER) begin
         kind = sstf_pkg::KIND_NUMBER;
      end else if (req_data.value >= sstf_pkg::MAX_MS) begin
         kind = sstf_pkg::KIND_CLOCK_MAX;
      end else if (req_data.value >= sstf_pkg::SPLIT_MS) begin
         kind = sstf_pkg::KIND_CLOCK;
      end else begin
         kind = sstf_pkg::KIND_CENTI;
      end
      case (kind)
         sstf_pkg::KIND_NUMBER: begin
            operand = {7'd0, req_data.value[15:0]};
            recip   = RECIP_10000;
         end
         sstf_pkg::KIND_CLOCK: begin
            operand = req_data.value[22:0];
            recip   = RECIP_1000;
         end
         default: begin
            operand = {7'd0, req_data.value[15:0]};
            recip   = RECIP_10;
         end
      endcase
   end

   assign product = {24'd0, operand} * {23'd0, recip};

   // Next work item
   always_comb begin
      front_work_in          = front_work_ff;
      front_valid_in         = front_valid_ff && !work_ready;
      if (req_fire) begin
         front_valid_in          = 1'b1;
         front_work_in.kind      = kind;
         front_work_in.num       = req_data.value[15:0];
         front_work_in.colon_on  = req_data.colon_on;
         front_work_in.keep      = req_data.keep_leading_zeros;
         case (kind)
            sstf_pkg::KIND_NUMBER: front_work_in.quot = product[42:30];
            sstf_pkg::KIND_CLOCK:  front_work_in.quot = product[45:33];
            sstf_pkg::KIND_CENTI:  front_work_in.quot = product[31:19];
            default:               front_work_in.quot = 13'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_work_ff <= front_work_in;
   end

endmodule

// ===== rtl/sstf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_queue
// Two-entry queue of work items between the front end and the back end.
// ----------------------------------------------------------------------------
module sstf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sstf_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sstf_pkg::work_type pop_data
);

   localparam int DEPTH     = 2;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   sstf_pkg::work_type     entry_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sstf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_back
// Splits a classified work item into four decimal digits over four stages,
// then builds the segment frame in the output register.
// ----------------------------------------------------------------------------
module sstf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_ready,
   input  sstf_pkg::work_type work_data,
   input  logic [7:0]         colon_pattern,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sstf_pkg::rsp_type  rsp_data
);

   // Reciprocals for the high/low split, shift of 20, operand below 10000
   localparam logic [14:0] RECIP_100 = 15'd10486;
   localparam logic [14:0] RECIP_60  = 15'd17477;
   localparam logic [13:0] NUM_MOD   = 14'd10000;

   typedef struct packed {
      sstf_pkg::kind_type kind;
      logic               colon_on;
      logic               keep;
   } ctrl_type;

   typedef struct packed {
      ctrl_type    ctrl;
      logic [13:0] whole;
      logic [6:0]  hi;
      logic [6:0]  lo;
   } split_type;

   typedef struct packed {
      ctrl_type   ctrl;
      logic [3:0] d0;
      logic [3:0] d1;
      logic [3:0] d2;
      logic [3:0] d3;
   } digit_type;

   // Tens and ones of a value below 100
   function automatic logic [7:0] split_digits(input logic [6:0] x);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {8'd0, x} * 15'd205;
      tens = prod[14:11];
      ones = x - 7'({3'd0, tens} * 7'd10);
      return {tens, ones[3:0]};
   endfunction

   logic        advance;
   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   split_type   s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   digit_type   s4_ff, s4_in;
   sstf_pkg::rsp_type out_ff, out_in;
   logic [15:0] num_base;
   logic [28:0] hi_prod;
   logic [7:0]  hi_digits, lo_digits;
   logic        is_number, blank_lead;

   // The whole pipe moves unless a finished frame is held
   assign advance    = !out_valid_ff || rsp_ready;
   assign work_ready = advance;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   // Stage 1: value to split (number modulo 10000, seconds or centiseconds)
   assign num_base = {13'd0, work_data.quot[2:0]} * {2'd0, NUM_MOD};
   always_comb begin
      s1_in               = '0;
      s1_in.ctrl.kind     = work_data.kind;
      s1_in.ctrl.colon_on = work_data.colon_on;
      s1_in.ctrl.keep     = work_data.keep;
      if (work_data.kind == sstf_pkg::KIND_NUMBER) begin
         s1_in.whole = 14'(work_data.num - num_base);
      end else begin
         s1_in.whole = {1'b0, work_data.quot};
      end
   end

   // Stage 2: high part (minutes or hundreds)
   assign hi_prod = {15'd0, s1_ff.whole} *
                    {14'd0, (s1_ff.ctrl.kind == sstf_pkg::KIND_CLOCK) ? RECIP_60 : RECIP_100};
   always_comb begin
      s2_in    = s1_ff;
      s2_in.hi = hi_prod[26:20];
      if (s1_ff.ctrl.kind == sstf_pkg::KIND_CLOCK_MAX) begin
         s2_in.hi = sstf_pkg::MAX_MINUTES;
      end
   end

   // Stage 3: low part (seconds or last two digits)
   always_comb begin
      s3_in = s2_ff;
      case (s2_ff.ctrl.kind)
         sstf_pkg::KIND_CLOCK:
            s3_in.lo = 7'(s2_ff.whole - 14'({7'd0, s2_ff.hi} * 14'd60));
         sstf_pkg::KIND_CLOCK_MAX:
            s3_in.lo = sstf_pkg::MAX_SECONDS;
         default:
            s3_in.lo = 7'(s2_ff.whole - 14'({7'd0, s2_ff.hi} * 14'd100));
      endcase
   end

   // Stage 4: four decimal digits
   assign hi_digits = split_digits(s3_ff.hi);
   assign lo_digits = split_digits(s3_ff.lo);
   always_comb begin
      s4_in.ctrl = s3_ff.ctrl;
      s4_in.d0   = hi_digits[7:4];
      s4_in.d1   = hi_digits[3:0];
      s4_in.d2   = lo_digits[7:4];
      s4_in.d3   = lo_digits[3:0];
   end

   // Output stage: segments, blanking, decimal point and colon
   assign is_number  = (s4_ff.ctrl.kind == sstf_pkg::KIND_NUMBER);
   assign blank_lead = is_number && !s4_ff.ctrl.keep;
   always_comb begin
      out_in.digit0_segments = sstf_pkg::segment_of(s4_ff.d0);
      if (s4_ff.d0 == 4'd0 && !(is_number && s4_ff.ctrl.keep)) begin
         out_in.digit0_segments = 8'h00;
      end
      out_in.digit1_segments = sstf_pkg::segment_of(s4_ff.d1);
      if (blank_lead && s4_ff.d0 == 4'd0 && s4_ff.d1 == 4'd0) begin
         out_in.digit1_segments = 8'h00;
      end
      if (s4_ff.ctrl.kind == sstf_pkg::KIND_CENTI) begin
         out_in.digit1_segments = out_in.digit1_segments | sstf_pkg::DOT_BIT;
      end
      out_in.digit2_segments = sstf_pkg::segment_of(s4_ff.d2);
      if (blank_lead && s4_ff.d0 == 4'd0 && s4_ff.d1 == 4'd0 && s4_ff.d2 == 4'd0) begin
         out_in.digit2_segments = 8'h00;
      end
      out_in.digit3_segments = sstf_pkg::segment_of(s4_ff.d3);
      case (s4_ff.ctrl.kind)
         sstf_pkg::KIND_NUMBER:
            out_in.colon_segments = s4_ff.ctrl.colon_on ? colon_pattern : 8'h00;
         sstf_pkg::KIND_CLOCK, sstf_pkg::KIND_CLOCK_MAX:
            out_in.colon_segments = s4_ff.d3[0] ? 8'h00 : colon_pattern;
         default:
            out_in.colon_segments = 8'h00;
      endcase
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= work_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         out_ff <= out_in;
      end
   end

endmodule

// ===== rtl/seven_segment_number_time_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_time_formatter
// Turns numbers or elapsed milliseconds into four-digit seven-segment frames.
//
//   Channel  Ports             Direction  Moves
//   request  req_valid/ready   in         action, value, colon_on, keep zeros
//   response rsp_valid/ready   out        five segment bytes of one frame
//   csr      csr_wr_en/data    in         colon pattern byte, reset 0x02
//
// One transaction per cycle sustained while responses are taken. A request
// passes through one front-end divide stage, the queue, four back-end digit
// stages and the output register. Reset is synchronous and empties the
// front register, the two-entry queue and the back-end stages. A held
// response stalls the back end; the queue lets the front end keep accepting.
// ----------------------------------------------------------------------------
module seven_segment_number_time_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sstf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sstf_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   logic [7:0]         colon_reg_ff, colon_reg_in;
   logic               front_valid, front_ready;
   sstf_pkg::work_type front_work;
   logic               queue_valid, queue_ready;
   sstf_pkg::work_type queue_work;

   // Colon pattern register
   assign colon_reg_in = csr_wr_en ? csr_wr_data : colon_reg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         colon_reg_ff <= sstf_pkg::COLON_RESET;
      end else begin
         colon_reg_ff <= colon_reg_in;
      end
   end

   sstf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .work_valid (front_valid),
      .work_ready (front_ready),
      .work_data  (front_work)
   );

   sstf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_work),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_work)
   );

   sstf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .work_valid    (queue_valid),
      .work_ready    (queue_ready),
      .work_data     (queue_work),
      .colon_pattern (colon_reg_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== dv/tb_seven_segment_number_time_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_number_time_formatter
// Self-checking bench for the seven-segment number and time frame formatter.
// Requests go in through a bursty valid/ready driver and frames come back
// through a stalling receiver. Each accepted request is formatted by a local
// model, and every returned frame is checked byte by byte against the oldest
// pending frame. A directed set covers digit blanking, the MM:SS and SS.cs
// formats and minute saturation. Random phases then run under several colon
// patterns, including 0x00 and 0xFF.
// ----------------------------------------------------------------------------
module tb_seven_segment_number_time_formatter;

   localparam int          HALF_PERIOD    = 4;
   localparam int          RESET_CYCLES   = 10;
   localparam int          DRAIN_CYCLES   = 12;
   localparam int          LONG_HOLD      = 300;
   localparam int          STALL_LIMIT    = 4000;
   localparam int          PHASE_ITEMS    = 350;
   localparam int unsigned MS_PER_MINUTE  = 60000;
   localparam int unsigned MS_SATURATE    = 6000000;
   localparam logic [7:0]  POINT_MASK     = 8'h80;
   localparam logic [7:0]  GLYPHS [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   sstf_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   sstf_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [7:0]        csr_wr_data = 8'h00;

   sstf_pkg::req_type pending_requests [$];
   sstf_pkg::rsp_type expected_frames [$];
   logic [7:0]        colon_pattern_model = 8'h02;
   logic              req_taken = 1'b0;
   int                error_count = 0;
   int                hold_requests = 0;
   int                hold_served = 0;

   seven_segment_number_time_formatter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Segment byte of one decimal digit
   function automatic logic [7:0] digit_glyph(input int unsigned digit);
      return GLYPHS[digit % 10];
   endfunction

   // Expected display frame of one request under the given colon pattern
   function automatic sstf_pkg::rsp_type format_frame(input sstf_pkg::req_type r,
                                                      input logic [7:0] pat);
      sstf_pkg::rsp_type f;
      int unsigned       n;
      int unsigned       dg [4];
      logic [7:0]        seg [4];
      bit                leading;
      int unsigned       secs_total;
      int unsigned       mins;
      int unsigned       secs;
      int unsigned       cs;
      f = '0;
      if (r.action == sstf_pkg::ACTION_NUMBER) begin
         n = {16'd0, r.value[15:0]};
         for (int i = 3; i >= 0; i--) begin
            dg[i] = n % 10;
            n = n / 10;
         end
         leading = 1'b1;
         for (int i = 0; i < 4; i++) begin
            if (!r.keep_leading_zeros && leading && dg[i] == 0 && i < 3) begin
               seg[i] = 8'h00;
            end else begin
               seg[i] = digit_glyph(dg[i]);
               leading = 1'b0;
            end
         end
         f.digit0_segments = seg[0];
         f.digit1_segments = seg[1];
         f.digit2_segments = seg[2];
         f.digit3_segments = seg[3];
         f.colon_segments  = r.colon_on ? pat : 8'h00;
      end else if (r.value >= MS_PER_MINUTE) begin
         // MM:SS, pinned at 99:59 from 100 minutes up
         secs_total = r.value / 1000;
         mins = secs_total / 60;
         secs = secs_total % 60;
         if (mins > 99) begin
            mins = 99;
            secs = 59;
         end
         f.digit0_segments = (mins >= 10) ? digit_glyph(mins / 10) : 8'h00;
         f.digit1_segments = digit_glyph(mins);
         f.colon_segments  = (secs % 2 == 0) ? pat : 8'h00;
         f.digit2_segments = digit_glyph(secs / 10);
         f.digit3_segments = digit_glyph(secs);
      end else begin
         // SS.cs with the point on the second digit
         cs = r.value / 10;
         f.digit0_segments = (cs >= 1000) ? digit_glyph(cs / 1000) : 8'h00;
         f.digit1_segments = digit_glyph(cs / 100) | POINT_MASK;
         f.colon_segments  = 8'h00;
         f.digit2_segments = digit_glyph(cs / 10);
         f.digit3_segments = digit_glyph(cs);
      end
      return f;
   endfunction

   function automatic sstf_pkg::req_type make_request(input logic act,
                                                      input logic [31:0] val,
                                                      input logic colon,
                                                      input logic keep);
      sstf_pkg::req_type r;
      r.action             = act;
      r.value              = val;
      r.colon_on           = colon;
      r.keep_leading_zeros = keep;
      return r;
   endfunction

   // Random request, weighted toward blanking and format boundaries
   function automatic sstf_pkg::req_type random_request();
      sstf_pkg::req_type r;
      int unsigned       pick;
      int unsigned       edge_pt;
      r.action             = $urandom_range(0, 1) ? sstf_pkg::ACTION_TIME
                                                  : sstf_pkg::ACTION_NUMBER;
      r.colon_on           = 1'($urandom_range(0, 1));
      r.keep_leading_zeros = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (r.action == sstf_pkg::ACTION_NUMBER) begin
         r.value = $urandom();
         if (pick < 2) begin
            r.value[15:0] = 16'($urandom_range(0, 99));
         end else if (pick < 4) begin
            r.value[15:0] = 16'($urandom_range(0, 9999));
         end
      end else begin
         case (pick)
            0, 1, 2: r.value = $urandom_range(0, MS_PER_MINUTE - 1);
            3, 4, 5: r.value = $urandom_range(MS_PER_MINUTE, MS_SATURATE - 1);
            6: begin
               case ($urandom_range(0, 3))
                  0: edge_pt = MS_PER_MINUTE;
                  1: edge_pt = 600000;
                  2: edge_pt = MS_SATURATE;
                  default: edge_pt = 10000;
               endcase
               r.value = edge_pt - 3 + $urandom_range(0, 6);
            end
            7: r.value = $urandom_range(32'hFFFF_FFFF, MS_SATURATE);
            default: r.value = $urandom();
         endcase
      end
      return r;
   endfunction

   task automatic check_byte(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %02h, got %02h", name, want, got);
         error_count++;
      end
   endtask

   // Wait until every request is out and every frame is back
   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_frames.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_colon(input logic [7:0] pat);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pat;
      colon_pattern_model = pat;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Request driver: bursts with random gaps, payload held until accepted
   int burst_left = 0;
   int gap_left   = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_requests[0];
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Frame receiver: duty-cycle stall pattern, plus long hold-offs on request
   int hold_left   = 0;
   int stall_tick  = 0;
   int stall_per   = 1;
   int stall_duty  = 1;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_tick % 64 == 0) begin
            stall_per  = $urandom_range(1, 7);
            stall_duty = ($urandom_range(0, 2) == 0) ? stall_per
                                                     : $urandom_range(1, stall_per);
         end
         rsp_ready <= (stall_tick % stall_per) < stall_duty;
         stall_tick++;
      end
   end

   // Transaction monitor: predicts on request, checks on response
   always @(posedge clock) begin
      sstf_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_frames.push_back(format_frame(req_data, colon_pattern_model));
            void'(pending_requests.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("frame received with none outstanding: %h", rsp_data);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               check_byte("digit0_segments", want.digit0_segments, rsp_data.digit0_segments);
               check_byte("digit1_segments", want.digit1_segments, rsp_data.digit1_segments);
               check_byte("colon_segments",  want.colon_segments,  rsp_data.colon_segments);
               check_byte("digit2_segments", want.digit2_segments, rsp_data.digit2_segments);
               check_byte("digit3_segments", want.digit3_segments, rsp_data.digit3_segments);
            end
         end
      end
   end

   // Watchdog: ends the run when outstanding work stops moving
   int stuck_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_requests.size() == 0 && expected_frames.size() == 0)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus sequence
   initial begin
      logic [7:0] patterns [5];
      patterns = '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h01};
      patterns[2] = 8'($urandom_range(1, 254));
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: blanking, wrap above 9999, format split, saturation
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd0, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd0, 1'b1, 1'b1));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd7, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd1005, 1'b1, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd9999, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd10000, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd10000, 1'b1, 1'b1));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'd65535, 1'b1, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'h0001_2345,
                                              1'b0, 1'b1));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_NUMBER, 32'hFFFF_0000,
                                              1'b1, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd0, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd9999, 1'b1, 1'b1));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd10000, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd59999, 1'b0, 1'b1));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd60000, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd61000, 1'b1, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd123456, 1'b1, 1'b1));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd599999, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd600000, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd5999999, 1'b0, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'd6000000, 1'b1, 1'b0));
      pending_requests.push_back(make_request(sstf_pkg::ACTION_TIME, 32'hFFFF_FFFF,
                                              1'b0, 1'b1));
      wait_drained();

      // Random phases, one colon pattern each; the second one holds the receiver off
      for (int p = 0; p < 5; p++) begin
         write_colon(patterns[p]);
         if (p == 1) begin
            hold_requests++;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_requests.push_back(random_request());
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
